// ===== hw/rtl/lhm_pkg.sv =====
// Shared types and constants for the latency histogram monitor.
// Used by every module of the block but lhm_bin_ram; depends on nothing.
`default_nettype none

package lhm_pkg;

	// Default geometry of the histogram.
	localparam int HIST_BINS_DEF       = 200;
	localparam int BIN_WIDTH_US_DEF    = 50;
	localparam int BIN_COUNT_WIDTH_DEF = 32;

	// Fixed field widths.
	localparam int OPC_W   = 2;
	localparam int LAT_W   = 48;
	localparam int BYTE_W  = 32;
	localparam int PCT_W   = 14;
	localparam int PCTL_W  = 24;
	localparam int CNT64_W = 64;
	localparam int OVF_W   = 32;

	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 536;

	// Arithmetic constants.
	localparam int NS_PER_US = 1000;
	localparam int PCT_SCALE = 10000;

	// Opcodes carried on the input tuser.
	localparam logic [OPC_W-1:0] OP_RECORD = 2'd0;
	localparam logic [OPC_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;
	// Opcode with no function; the block drops it.
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WR,
		ST_QSTART,
		ST_QUERY,
		ST_OUT
	} ctl_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_RUN,
		SC_DONE
	} scan_state_t;

	// Status of the percentile scan as seen by the controller.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PCTL_W-1:0] pct_ns;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lhm_bin_ram.sv =====
// Histogram bin count memory: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`default_nettype none

module lhm_bin_ram #(
	parameter int DEPTH = 200,
	parameter int AW    = 8,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lhm_bin_div.sv =====
// Bin index unit: divides a latency by the bin width in ns through a registered
// reciprocal multiplication, with an early overflow check. Uses lhm_pkg.
`default_nettype none

module lhm_bin_div
	import lhm_pkg::*;
#(
	parameter int HIST_BINS    = HIST_BINS_DEF,
	parameter int BIN_WIDTH_US = BIN_WIDTH_US_DEF,
	parameter int AW           = $clog2(HIST_BINS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LAT_W-1:0] lat,
	output logic                  done,
	output logic                  ovf,
	output logic      [AW-1:0]    bin
);

	localparam longint unsigned BIN_DIV_L   = longint'(BIN_WIDTH_US) * longint'(NS_PER_US);
	localparam longint unsigned OVF_BOUND_L = BIN_DIV_L * longint'(HIST_BINS);
	localparam logic [LAT_W-1:0] OVF_BOUND  = LAT_W'(OVF_BOUND_L);

	// Latencies inside the histogram fit XW bits. With a shift of XW plus the
	// divisor's bit length, the rounded-up reciprocal gives the exact quotient
	// for every such latency.
	localparam int XW   = $clog2(OVF_BOUND_L);
	localparam int SH   = XW + $clog2(BIN_DIV_L);
	localparam int MW   = XW + 1;
	localparam int LO_W = (XW + 1) / 2;
	localparam int HI_W = XW - LO_W;
	localparam int PW   = XW + MW;
	localparam logic [127:0] RECIP_WIDE =
		((128'd1 << SH) + 128'(BIN_DIV_L) - 128'd1) / 128'(BIN_DIV_L);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_WIDE);

	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [LO_W+MW-1:0]   pp_lo_q;
	logic [HI_W+MW-1:0]   pp_hi_q;
	logic [AW-1:0]        bin_q;
	logic [PW-1:0]        prod;

	assign prod = PW'(pp_lo_q) + (PW'(pp_hi_q) << LO_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
			if (start) begin
				if (lat >= OVF_BOUND) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Start registers two half-width partial products; busy then sums and shifts them.
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q   <= (lat >= OVF_BOUND);
			pp_lo_q <= (LO_W+MW)'(lat[LO_W-1:0]) * (LO_W+MW)'(RECIP);
			pp_hi_q <= (HI_W+MW)'(lat[XW-1:LO_W]) * (HI_W+MW)'(RECIP);
		end
		if (busy_q) begin
			bin_q <= AW'(prod >> SH);
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign bin  = bin_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lhm_pct_scan.sv =====
// Percentile scan: forms pct*total, then streams the bins out of the memory,
// accumulating count*10000 until the target is met or every bin is read. Uses lhm_pkg.
`default_nettype none

module lhm_pct_scan
	import lhm_pkg::*;
#(
	parameter int HIST_BINS       = HIST_BINS_DEF,
	parameter int BIN_WIDTH_US    = BIN_WIDTH_US_DEF,
	parameter int BIN_COUNT_WIDTH = BIN_COUNT_WIDTH_DEF,
	parameter int AW              = $clog2(HIST_BINS),
	parameter int TOT_W           = 41
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [TOT_W-1:0]           total,
	input  wire logic [PCT_W-1:0]           pct,
	output logic                            rd_en,
	output logic      [AW-1:0]              rd_addr,
	input  wire logic [BIN_COUNT_WIDTH-1:0] rd_data,
	output scan_stat_t                      stat
);

	localparam int IW     = $clog2(HIST_BINS + 1);
	localparam int LO_W   = (TOT_W + 1) / 2;
	localparam int HI_W   = TOT_W - LO_W;
	localparam int CMP_W  = TOT_W + PCT_W;
	localparam int PROD_W = BIN_COUNT_WIDTH + PCT_W;
	localparam longint unsigned BIN_DIV_L = longint'(BIN_WIDTH_US) * longint'(NS_PER_US);
	localparam logic [LAT_W-1:0]  BIN_DIV = LAT_W'(BIN_DIV_L);
	localparam logic [PCTL_W-1:0] OVF_ANS = PCTL_W'(BIN_DIV_L * longint'(HIST_BINS));

	scan_state_t state_q, state_d;

	logic [LO_W+PCT_W-1:0] pp_lo_q;
	logic [HI_W+PCT_W-1:0] pp_hi_q;
	logic [CMP_W-1:0]      target_q;
	logic [CMP_W-1:0]      cum_q;
	logic [CMP_W-1:0]      cum_next;
	logic [LAT_W-1:0]      ub_q;
	logic [LAT_W-1:0]      ub_next;
	logic [IW-1:0]         idx_q;
	logic [PCTL_W-1:0]     ans_q;
	logic [PROD_W-1:0]     prod_s2;
	logic                  vld_s1;
	logic                  vld_s2;
	logic                  found_q;
	logic                  issue_end;
	logic                  take;
	logic                  hit;

	assign issue_end = (idx_q == IW'(HIST_BINS));
	assign rd_en     = (state_q == SC_RUN) && !found_q && !issue_end;
	assign rd_addr   = idx_q[AW-1:0];
	assign cum_next  = cum_q + CMP_W'(prod_s2);
	assign ub_next   = ub_q + BIN_DIV;
	assign take      = (state_q == SC_RUN) && vld_s2 && !found_q;
	assign hit       = take && (cum_next >= target_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE: begin
				if (start) begin
					state_d = (total == '0) ? SC_DONE : SC_MUL;
				end
			end
			SC_MUL: begin
				state_d = SC_RUN;
			end
			SC_RUN: begin
				if (found_q || (issue_end && !vld_s1 && !vld_s2)) begin
					state_d = SC_DONE;
				end
			end
			SC_DONE: begin
				state_d = SC_IDLE;
			end
			default: begin
				state_d = SC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			vld_s2  <= vld_s1;
			if (state_q == SC_MUL) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(rd_data) * PROD_W'(PCT_SCALE);
		if (state_q == SC_IDLE && start) begin
			pp_lo_q <= (LO_W+PCT_W)'(total[LO_W-1:0]) * (LO_W+PCT_W)'(pct);
			pp_hi_q <= (HI_W+PCT_W)'(total[TOT_W-1:LO_W]) * (HI_W+PCT_W)'(pct);
			ans_q   <= '0;
		end
		if (state_q == SC_MUL) begin
			target_q <= CMP_W'(pp_lo_q) + (CMP_W'(pp_hi_q) << LO_W);
			cum_q    <= '0;
			ub_q     <= '0;
			idx_q    <= '0;
			ans_q    <= OVF_ANS;
		end
		if (rd_en) begin
			idx_q <= idx_q + IW'(1);
		end
		if (take) begin
			cum_q <= cum_next;
			ub_q  <= ub_next;
			if (hit) begin
				ans_q <= ub_next[PCTL_W-1:0];
			end
		end
	end

	assign stat.busy   = (state_q != SC_IDLE);
	assign stat.done   = (state_q == SC_DONE);
	assign stat.pct_ns = ans_q;

endmodule

`default_nettype wire

// ===== hw/rtl/latency_histogram_monitor.sv =====
// Latency histogram monitor, top level: controller, scalar counters and output register.
// Uses lhm_pkg, lhm_bin_ram, lhm_bin_div and lhm_pct_scan.
//
// Usage. Items enter on the s_ channel; s_tuser carries the opcode (record, query,
// clear) and s_tdata the operands. A record counts one I/O completion and bins its
// latency; a clear returns every statistic to its reset value; a query produces one
// item on the m_ channel with the percentile bound and a snapshot of all counters.
// Records and clears produce no output item, and an unused opcode is dropped.
// The block works on one item at a time. A record whose latency lands beyond the
// last bin passes through the bin index unit only; any other record passes through
// the bin index unit, which finds the bin by a reciprocal multiplication, then one
// read and one write of the bin memory. A query is paced by the scan, which reads
// one bin of the memory per cycle; it ends early once the percentile is reached.
// A clear writes one memory entry per cycle. After reset the same clearing pass
// runs before the first item is taken. A query result sits in an output register;
// while the receiver stalls, the block keeps taking records and clears, and only a
// further query waits until the earlier result has been taken.
`default_nettype none

module latency_histogram_monitor
	import lhm_pkg::*;
#(
	parameter int HIST_BINS       = HIST_BINS_DEF,
	parameter int BIN_WIDTH_US    = BIN_WIDTH_US_DEF,
	parameter int BIN_COUNT_WIDTH = BIN_COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// latency[47:0], byte count[79:48], write flag[80], percentile[94:81], zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  wire logic [OPC_W-1:0]     s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// percentile_ns[23:0], read_op_total[87:24], write_op_total[151:88],
	// read_byte_total[215:152], write_byte_total[279:216], min_latency_ns[327:280],
	// max_latency_ns[375:328], latency_sum_ns[439:376], latency_count[503:440],
	// overflow_count[535:504]
	output logic      [M_TDATA_W-1:0] m_tdata
);

	localparam int AW    = $clog2(HIST_BINS);
	localparam int CW    = (BIN_COUNT_WIDTH > OVF_W) ? BIN_COUNT_WIDTH : OVF_W;
	localparam int TOT_W = CW + $clog2(HIST_BINS + 1);
	localparam int BCW   = BIN_COUNT_WIDTH;

	// Input fields.
	logic [LAT_W-1:0]  in_lat;
	logic [BYTE_W-1:0] in_bytes;
	logic              in_wr;
	logic [PCT_W-1:0]  in_pct;

	assign in_lat   = s_tdata[47:0];
	assign in_bytes = s_tdata[79:48];
	assign in_wr    = s_tdata[80];
	assign in_pct   = s_tdata[94:81];

	ctl_state_t state_q, state_d;

	// Statistics registers.
	logic [CNT64_W-1:0] reads_q;
	logic [CNT64_W-1:0] writes_q;
	logic [CNT64_W-1:0] rbytes_q;
	logic [CNT64_W-1:0] wbytes_q;
	logic [LAT_W-1:0]   low_q;
	logic [LAT_W-1:0]   high_q;
	logic [CNT64_W-1:0] lat_sum_q;
	logic [CNT64_W-1:0] rec_cnt_q;
	logic [OVF_W-1:0]   ovf_q;
	logic [TOT_W-1:0]   total_q;

	logic [PCT_W-1:0]     pct_q;
	logic [AW-1:0]        clr_idx_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Memory and unit hookups.
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [BCW-1:0] ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [BCW-1:0] ram_rdata;

	logic           div_start;
	logic           div_done;
	logic           div_ovf;
	logic [AW-1:0]  div_bin;

	logic           scan_start;
	logic           scan_rd_en;
	logic [AW-1:0]  scan_rd_addr;
	scan_stat_t     scan_stat;

	logic           accept;
	logic           rec_acc;
	logic           clr_acc;
	logic           out_load;
	logic           bin_sat;
	logic           ovf_inc;
	logic           bin_inc;
	logic [LAT_W-1:0] min_out;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign rec_acc  = accept && (s_tuser == OP_RECORD);
	assign clr_acc  = accept && (s_tuser == OP_CLEAR);
	assign bin_sat  = (ram_rdata == {BCW{1'b1}});

	// Overflow records bump the overflow bin; in-range records bump one memory entry.
	assign ovf_inc = (state_q == ST_DIV) && div_done && div_ovf && (ovf_q != {OVF_W{1'b1}});
	assign bin_inc = (state_q == ST_WR) && !bin_sat;

	lhm_bin_ram #(
		.DEPTH (HIST_BINS),
		.AW    (AW),
		.DW    (BCW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lhm_bin_div #(
		.HIST_BINS    (HIST_BINS),
		.BIN_WIDTH_US (BIN_WIDTH_US),
		.AW           (AW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.lat    (in_lat),
		.done   (div_done),
		.ovf    (div_ovf),
		.bin    (div_bin)
	);

	lhm_pct_scan #(
		.HIST_BINS       (HIST_BINS),
		.BIN_WIDTH_US    (BIN_WIDTH_US),
		.BIN_COUNT_WIDTH (BCW),
		.AW              (AW),
		.TOT_W           (TOT_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.total   (total_q),
		.pct     (pct_q),
		.rd_en   (scan_rd_en),
		.rd_addr (scan_rd_addr),
		.rd_data (ram_rdata),
		.stat    (scan_stat)
	);

	// Controller: next state and the memory port controls. The record path reads the
	// bin in the cycle the index unit finishes and writes it back in the next, so no
	// two accesses to one entry ever overlap.
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_idx_q;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = div_bin;
		div_start  = 1'b0;
		scan_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_idx_q == AW'(HIST_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						OP_RECORD: begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
						OP_QUERY: begin
							state_d = ST_QSTART;
						end
						OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_ovf) begin
						state_d = ST_IDLE;
					end else begin
						ram_re  = 1'b1;
						state_d = ST_WR;
					end
				end
			end
			ST_WR: begin
				// Saturated bins stay where they are.
				ram_we    = !bin_sat;
				ram_waddr = div_bin;
				ram_wdata = ram_rdata + BCW'(1);
				state_d   = ST_IDLE;
			end
			ST_QSTART: begin
				scan_start = 1'b1;
				state_d    = ST_QUERY;
			end
			ST_QUERY: begin
				if (scan_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (scan_rd_en) begin
			ram_re    = 1'b1;
			ram_raddr = scan_rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_acc) begin
				clr_idx_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Statistics. The scalar counters update on the cycle a record is accepted;
	// the histogram total follows each bin or overflow increment that really happens.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q   <= '0;
			writes_q  <= '0;
			rbytes_q  <= '0;
			wbytes_q  <= '0;
			low_q     <= '1;
			high_q    <= '0;
			lat_sum_q <= '0;
			rec_cnt_q <= '0;
			ovf_q     <= '0;
			total_q   <= '0;
		end else if (clr_acc) begin
			reads_q   <= '0;
			writes_q  <= '0;
			rbytes_q  <= '0;
			wbytes_q  <= '0;
			low_q     <= '1;
			high_q    <= '0;
			lat_sum_q <= '0;
			rec_cnt_q <= '0;
			ovf_q     <= '0;
			total_q   <= '0;
		end else begin
			if (rec_acc) begin
				if (in_wr) begin
					writes_q <= writes_q + CNT64_W'(1);
					wbytes_q <= wbytes_q + CNT64_W'(in_bytes);
				end else begin
					reads_q  <= reads_q + CNT64_W'(1);
					rbytes_q <= rbytes_q + CNT64_W'(in_bytes);
				end
				if (in_lat < low_q) begin
					low_q <= in_lat;
				end
				if (in_lat > high_q) begin
					high_q <= in_lat;
				end
				lat_sum_q <= lat_sum_q + CNT64_W'(in_lat);
				rec_cnt_q <= rec_cnt_q + CNT64_W'(1);
			end
			if (ovf_inc) begin
				ovf_q <= ovf_q + OVF_W'(1);
			end
			if (ovf_inc || bin_inc) begin
				total_q <= total_q + TOT_W'(1);
			end
		end
	end

	assign min_out = (rec_cnt_q == '0) ? '0 : low_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			pct_q <= in_pct;
		end
		if (out_load) begin
			m_tdata_q <= {ovf_q, rec_cnt_q, lat_sum_q, high_q, min_out,
				wbytes_q, rbytes_q, writes_q, reads_q, scan_stat.pct_ns};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
